FILE: rtl/voiced_block_router_defines.svh
// Assertion macros used by voiced_block_router to check its own logic.
`ifndef VOICED_BLOCK_ROUTER_DEFINES_SVH
`define VOICED_BLOCK_ROUTER_DEFINES_SVH

`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define VBR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define VBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VBR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define VBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/vbr_pkg.sv
package vbr_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_BITS      = 18;
    localparam int COEF_FRAC_BITS = 16;
    localparam int Y_BITS         = 24;
    localparam int POWER_BITS     = 40;
    localparam int BAND_BITS      = 48;
    localparam int MAX_BLOCK      = 512;
    localparam int COUNT_BITS     = $clog2(MAX_BLOCK + 1);
    localparam int CROSS_BITS     = 9;
    localparam int SHIFT_BITS     = 15;

    // Shared multiplier: every operand fits in 25 signed bits.
    localparam int MUL_BITS  = 25;
    localparam int PROD_BITS = 2 * MUL_BITS;
    localparam int ACC_BITS  = 44;

    // Loudness test: power_sum * 10^6 against N * 2^(2*(SAMPLE_BITS-1)).
    localparam int POWER_HALF     = POWER_BITS / 2;
    localparam int MILLION        = 1000000;
    localparam int HALF_PROD_BITS = POWER_HALF + 20;
    localparam int LOUD_BITS      = HALF_PROD_BITS + POWER_HALF + 1;
    localparam int REF_SHIFT      = 2 * (SAMPLE_BITS - 1);

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 18;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PITCH    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FORMANT  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_KIND     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN     = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FB_ONE   = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FB_TWO   = 3'd6;

    localparam logic [2:0] MODE_PASS    = 3'd0;
    localparam logic [2:0] MODE_VOCODER = 3'd1;
    localparam logic [2:0] MODE_SINUS   = 3'd2;
    localparam logic [2:0] MODE_SOURCE  = 3'd3;
    localparam logic [2:0] MODE_HYBRID  = 3'd4;

    localparam logic [1:0] ROUTE_PASS    = 2'd0;
    localparam logic [1:0] ROUTE_VOCODER = 2'd1;
    localparam logic [1:0] ROUTE_WSOLA   = 2'd2;
    localparam logic [1:0] ROUTE_SOURCE  = 2'd3;

    localparam logic [1:0] KIND_LITE     = 2'd0;
    localparam logic [1:0] KIND_SOLO     = 2'd1;
    localparam logic [1:0] KIND_ENSEMBLE = 2'd2;
    localparam logic [1:0] KIND_BACKING  = 2'd3;

    localparam logic signed [SHIFT_BITS-1:0] SHIFT_LIMIT = 15'sd128;

    localparam logic signed [COEF_BITS-1:0] GAIN_RESET   = 18'sd5929;
    localparam logic signed [COEF_BITS-1:0] FB_ONE_RESET = 18'sd113838;
    localparam logic signed [COEF_BITS-1:0] FB_TWO_RESET = 18'sd53677;

endpackage

FILE: rtl/vbr_if.sv
interface vbr_in_if import vbr_pkg::*;;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          block_end;

    modport source (output valid, output sample, output block_end, input ready);
    modport sink   (input valid, input sample, input block_end, output ready);
endinterface

interface vbr_out_if import vbr_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [1:0]            route;
    logic                  polyphonic;
    logic                  voiced;
    logic [CROSS_BITS-1:0] crossing_count;

    modport source (output valid, output route, output polyphonic, output voiced,
                    output crossing_count, input ready);
    modport sink   (input valid, input route, input polyphonic, input voiced,
                    input crossing_count, output ready);
endinterface

interface vbr_cfg_if import vbr_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/vbr_mul.sv
// Shared signed multiplier with its product registered.
module vbr_mul import vbr_pkg::*;
(
    input  logic                        clk,
    input  logic signed [MUL_BITS-1:0]  a,
    input  logic signed [MUL_BITS-1:0]  b,
    output logic signed [PROD_BITS-1:0] prod
);

    logic signed [PROD_BITS-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/voiced_block_router.sv
// Channel   | Dir  | Payload                                         | Accepted when
// samples   | in   | sample (16 signed), block_end (1)               | valid && ready
// routes    | out  | route (2), polyphonic, voiced, crossing_count(9)| valid && ready
// cfg       | in   | index (3), data (18)                            | valid && ready
//
// After a sample that does not end its block is accepted, samples.ready stays low while
// states M0 to M6 run, so the next sample waits meanwhile: five products go through
// the one 25x25 multiplier in turn, and the last state folds y squared into the band sum.
// After a sample that ends its block, samples.ready stays low through M0 to M6, D0 to D2
// and OUT, which also waits while the output register is still full; the loudness test takes two more
// multiplier passes and one wide compare.
// rst_n clears all block state and restores the configuration registers at once.
// A finished result sits in the output register, so the next sample is taken while it
// waits; only the next block end stalls until routes.ready has emptied that register.
`include "voiced_block_router_defines.svh"

module voiced_block_router import vbr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    vbr_in_if.sink  samples,
    vbr_out_if.source routes,
    vbr_cfg_if.sink cfg
);

    // Sequencer states. M0 to M3 and M5 each issue one product; M1 to M4 and M6 each use the previous one.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M0   = 4'd1;
    localparam logic [3:0] S_M1   = 4'd2;
    localparam logic [3:0] S_M2   = 4'd3;
    localparam logic [3:0] S_M3   = 4'd4;
    localparam logic [3:0] S_M4   = 4'd5;
    localparam logic [3:0] S_M5   = 4'd6;
    localparam logic [3:0] S_M6   = 4'd7;
    localparam logic [3:0] S_D0   = 4'd8;
    localparam logic [3:0] S_D1   = 4'd9;
    localparam logic [3:0] S_D2   = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    localparam logic signed [ACC_BITS-1:0] ROUND = ACC_BITS'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [Y_BITS-1:0]   Y_MAX = {1'b0, {(Y_BITS-1){1'b1}}};
    localparam logic signed [Y_BITS-1:0]   Y_MIN = {1'b1, {(Y_BITS-1){1'b0}}};
    localparam int Y_SHIFTED_BITS = ACC_BITS - COEF_FRAC_BITS;

    logic [3:0] state_reg, state_next;

    // Configuration registers.
    logic [2:0]                    mode_reg;
    logic signed [SHIFT_BITS-1:0]  pitch_reg;
    logic signed [SHIFT_BITS-1:0]  formant_reg;
    logic [1:0]                    kind_reg;
    logic signed [COEF_BITS-1:0]   gain_reg;
    logic signed [COEF_BITS-1:0]   fb_one_reg;
    logic signed [COEF_BITS-1:0]   fb_two_reg;

    // Block state.
    logic                          prev_nonneg_reg;
    logic [COUNT_BITS-1:0]         count_reg;
    logic [CROSS_BITS-1:0]         cross_reg;
    logic [POWER_BITS-1:0]         power_reg;
    logic [BAND_BITS-1:0]          band_reg;
    logic signed [SAMPLE_BITS-1:0] x1_reg, x2_reg;
    logic signed [Y_BITS-1:0]      y1_reg, y2_reg;

    // Working registers for the item in flight.
    logic signed [SAMPLE_BITS-1:0] s_reg;
    logic signed [SAMPLE_BITS:0]   diff_reg;
    logic                          end_reg;
    logic signed [ACC_BITS-1:0]    acc_reg;
    logic [HALF_PROD_BITS-1:0]     hi_reg;
    logic                          loud_reg;

    // Output register.
    logic                  out_valid_reg;
    logic [1:0]            out_route_reg;
    logic                  out_poly_reg;
    logic                  out_voiced_reg;
    logic [CROSS_BITS-1:0] out_cross_reg;

    logic signed [MUL_BITS-1:0]  mul_a, mul_b;
    logic signed [PROD_BITS-1:0] prod;

    vbr_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    logic in_fire;
    logic out_free;
    assign samples.ready = (state_reg == S_IDLE);
    assign in_fire       = samples.valid && samples.ready;
    assign out_free      = !out_valid_reg || routes.ready;
    assign cfg.ready     = 1'b1;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_M0:
            begin
                mul_a = MUL_BITS'(s_reg);
                mul_b = MUL_BITS'(s_reg);
            end
            S_M1:
            begin
                mul_a = MUL_BITS'(gain_reg);
                mul_b = MUL_BITS'(diff_reg);
            end
            S_M2:
            begin
                mul_a = MUL_BITS'(fb_one_reg);
                mul_b = MUL_BITS'(y1_reg);
            end
            S_M3:
            begin
                mul_a = MUL_BITS'(fb_two_reg);
                mul_b = MUL_BITS'(y2_reg);
            end
            S_M5:
            begin
                mul_a = MUL_BITS'(y1_reg);
                mul_b = MUL_BITS'(y1_reg);
            end
            S_D0:
            begin
                mul_a = {{(MUL_BITS-POWER_HALF){1'b0}}, power_reg[POWER_BITS-1:POWER_HALF]};
                mul_b = MUL_BITS'(MILLION);
            end
            S_D1:
            begin
                mul_a = {{(MUL_BITS-POWER_HALF){1'b0}}, power_reg[POWER_HALF-1:0]};
                mul_b = MUL_BITS'(MILLION);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Filter output: remove the last feedback term, floor-shift, then saturate.
    // The rounding constant was folded into the accumulator when it was seeded.
    logic signed [ACC_BITS-1:0]       acc_final;
    logic signed [Y_SHIFTED_BITS-1:0] y_wide;
    logic signed [Y_BITS-1:0]         y_sat;
    always_comb
    begin
        acc_final = acc_reg - prod[ACC_BITS-1:0];
        y_wide    = acc_final[ACC_BITS-1:COEF_FRAC_BITS];
        if (y_wide > Y_SHIFTED_BITS'(Y_MAX))
        begin
            y_sat = Y_MAX;
        end
        else if (y_wide < Y_SHIFTED_BITS'(Y_MIN))
        begin
            y_sat = Y_MIN;
        end
        else
        begin
            y_sat = y_wide[Y_BITS-1:0];
        end
    end

    // Saturating energy sums. Each sum is capped at all ones.
    logic [POWER_BITS:0] power_sum_wide;
    logic [BAND_BITS:0]  band_sum_wide;
    assign power_sum_wide = {1'b0, power_reg} + (POWER_BITS + 1)'(prod[2*SAMPLE_BITS-1:0]);
    assign band_sum_wide  = {1'b0, band_reg} + (BAND_BITS + 1)'(prod[2*Y_BITS-1:0]);

    // Loudness: the two partial products of power_sum * 10^6 against N scaled to full scale.
    logic [LOUD_BITS-1:0] loud_product;
    logic [LOUD_BITS-1:0] loud_ref;
    assign loud_product = {1'b0, hi_reg, {POWER_HALF{1'b0}}}
                        + LOUD_BITS'(prod[HALF_PROD_BITS-1:0]);
    assign loud_ref     = LOUD_BITS'(count_reg) << REF_SHIFT;

    // Decision logic, read in the output state once every sum is final.
    logic                  has_pitch, has_formant, solo, poly;
    logic                  few_crossings, band_strong, voiced;
    logic [15:0]           cross_x20, count_x3;
    logic [BAND_BITS+5:0]  band_x20;
    logic [1:0]            route;
    always_comb
    begin
        has_pitch   = (pitch_reg > SHIFT_LIMIT) || (pitch_reg < -SHIFT_LIMIT);
        has_formant = (formant_reg > SHIFT_LIMIT) || (formant_reg < -SHIFT_LIMIT);
        solo        = (kind_reg == KIND_SOLO);
        poly        = (kind_reg == KIND_ENSEMBLE) || (kind_reg == KIND_BACKING);

        cross_x20     = (16'(cross_reg) << 4) + (16'(cross_reg) << 2);
        count_x3      = (16'(count_reg) << 1) + 16'(count_reg);
        few_crossings = cross_x20 < count_x3;

        band_x20    = ((BAND_BITS + 6)'(band_reg) << 4) + ((BAND_BITS + 6)'(band_reg) << 2);
        band_strong = band_x20 > (BAND_BITS + 6)'(power_reg);

        voiced = has_pitch && !has_formant && solo && few_crossings && loud_reg
              && band_strong;

        case (mode_reg)
            MODE_VOCODER, MODE_SINUS:
            begin
                route = ROUTE_VOCODER;
            end
            MODE_SOURCE:
            begin
                route = ROUTE_SOURCE;
            end
            MODE_HYBRID:
            begin
                if (has_formant || voiced)
                begin
                    route = ROUTE_SOURCE;
                end
                else if (poly && !has_pitch)
                begin
                    route = ROUTE_WSOLA;
                end
                else
                begin
                    route = ROUTE_VOCODER;
                end
            end
            default:
            begin
                route = ROUTE_PASS;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_fire) state_next = S_M0;
            S_M0:   state_next = S_M1;
            S_M1:   state_next = S_M2;
            S_M2:   state_next = S_M3;
            S_M3:   state_next = S_M4;
            S_M4:   state_next = S_M5;
            S_M5:   state_next = S_M6;
            S_M6:   state_next = end_reg ? S_D0 : S_IDLE;
            S_D0:   state_next = S_D1;
            S_D1:   state_next = S_D2;
            S_D2:   state_next = S_OUT;
            S_OUT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_PASS;
            pitch_reg   <= '0;
            formant_reg <= '0;
            kind_reg    <= KIND_LITE;
            gain_reg    <= GAIN_RESET;
            fb_one_reg  <= FB_ONE_RESET;
            fb_two_reg  <= FB_TWO_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_MODE:    mode_reg    <= cfg.data[2:0];
                CFG_PITCH:   pitch_reg   <= cfg.data[SHIFT_BITS-1:0];
                CFG_FORMANT: formant_reg <= cfg.data[SHIFT_BITS-1:0];
                CFG_KIND:    kind_reg    <= cfg.data[1:0];
                CFG_GAIN:    gain_reg    <= cfg.data[COEF_BITS-1:0];
                CFG_FB_ONE:  fb_one_reg  <= cfg.data[COEF_BITS-1:0];
                CFG_FB_TWO:  fb_two_reg  <= cfg.data[COEF_BITS-1:0];
                default:     ;
            endcase
        end
    end

    // Block state: sign tracking and the input delay line move on acceptance, the sums and
    // output delay line as their products arrive, and all of it clears when a result is
    // written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_nonneg_reg <= 1'b0;
            count_reg       <= '0;
            cross_reg       <= '0;
            power_reg       <= '0;
            band_reg        <= '0;
            x1_reg          <= '0;
            x2_reg          <= '0;
            y1_reg          <= '0;
            y2_reg          <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                // The first sample of a block is never compared with the previous sign.
                if ((count_reg != '0) && (prev_nonneg_reg == samples.sample[SAMPLE_BITS-1]))
                begin
                    cross_reg <= cross_reg + 1'b1;
                end
                prev_nonneg_reg <= !samples.sample[SAMPLE_BITS-1];
                count_reg       <= count_reg + 1'b1;
                x1_reg          <= samples.sample;
                x2_reg          <= x1_reg;
            end
            if (state_reg == S_M1)
            begin
                power_reg <= power_sum_wide[POWER_BITS] ? {POWER_BITS{1'b1}}
                                                        : power_sum_wide[POWER_BITS-1:0];
            end
            if (state_reg == S_M4)
            begin
                y1_reg <= y_sat;
                y2_reg <= y1_reg;
            end
            if (state_reg == S_M6)
            begin
                band_reg <= band_sum_wide[BAND_BITS] ? {BAND_BITS{1'b1}}
                                                     : band_sum_wide[BAND_BITS-1:0];
            end
            if ((state_reg == S_OUT) && out_free)
            begin
                prev_nonneg_reg <= 1'b0;
                count_reg       <= '0;
                cross_reg       <= '0;
                power_reg       <= '0;
                band_reg        <= '0;
                x1_reg          <= '0;
                x2_reg          <= '0;
                y1_reg          <= '0;
                y2_reg          <= '0;
            end
        end
    end

    // Working registers of the item in flight.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s_reg    <= samples.sample;
            diff_reg <= (SAMPLE_BITS + 1)'(samples.sample) - (SAMPLE_BITS + 1)'(x2_reg);
            // A block that reaches its maximum length ends here as if flagged.
            end_reg  <= samples.block_end || (count_reg == COUNT_BITS'(MAX_BLOCK - 1));
        end
        if (state_reg == S_M2)
        begin
            acc_reg <= prod[ACC_BITS-1:0] + ROUND;
        end
        if (state_reg == S_M3)
        begin
            acc_reg <= acc_reg + prod[ACC_BITS-1:0];
        end
        if (state_reg == S_D1)
        begin
            hi_reg <= prod[HALF_PROD_BITS-1:0];
        end
        if (state_reg == S_D2)
        begin
            loud_reg <= loud_product > loud_ref;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_OUT) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (routes.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_OUT) && out_free)
        begin
            out_route_reg  <= route;
            out_poly_reg   <= poly;
            out_voiced_reg <= voiced;
            out_cross_reg  <= cross_reg;
        end
    end

    assign routes.valid          = out_valid_reg;
    assign routes.route          = out_route_reg;
    assign routes.polyphonic     = out_poly_reg;
    assign routes.voiced         = out_voiced_reg;
    assign routes.crossing_count = out_cross_reg;

    // One sample at a time: an accepted sample closes the input for the next cycle.
    `VBR_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_fire, !samples.ready,
                     "sample taken while busy")
    // An empty block carries no crossings and no energy.
    `VBR_ASSERT_SAME(a_empty_block, clk, rst_n, count_reg == '0,
                     (cross_reg == '0) && (power_reg == '0) && (band_reg == '0),
                     "empty block holds stale sums")
    // A result is only written for a block that has samples.
    `VBR_ASSERT_SAME(a_out_nonempty, clk, rst_n, state_reg == S_OUT, count_reg != '0,
                     "result for an empty block")

endmodule
